// ===== sv/pointer_position_tracker_top_defines.svh =====
// Assertion macros shared by the pointer tracker checker.
`ifndef POINTER_POSITION_TRACKER_TOP_DEFINES_SVH
`define POINTER_POSITION_TRACKER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is low.
`define PPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is low.
`define PPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ppt_pkg.sv =====
// Shared types and constants for the pointer position tracker.
`default_nettype none

package ppt_pkg;

  typedef enum logic [2:0] {
    ACT_MOVE_REL    = 3'd0,
    ACT_MOVE_ABS    = 3'd1,
    ACT_BUTTON      = 3'd2,
    ACT_WHEEL       = 3'd3,
    ACT_TAKE_WHEEL  = 3'd4,
    ACT_QUERY       = 3'd5,
    ACT_SET_PRESENT = 3'd6,
    ACT_NONE        = 3'd7
  } action_t;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

endpackage

`default_nettype wire

// ===== sv/pointer_position_tracker_top.sv =====
// Pointer position tracker: returns a state snapshot per mouse event. Each accepted beat
// updates position, buttons, wheel total or present flag as its action selects, and loads
// the result register, which shows in the cycle after acceptance. Input is ready when the
// result register is empty or being taken, so one event per clock is taken while results
// are taken. The user must write screen size registers through the cfg port only while no
// event is in flight; the block does not enforce it. Only a nonzero size clamps position.
`default_nettype none

module pointer_position_tracker_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // configuration
  input  wire logic                                 cfg_we,
  input  wire logic [ppt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [ppt_pkg::CFG_DATA_W-1:0]       cfg_data,
  // event channel
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [2:0]                           in_action,
  input  wire logic signed [15:0]                   in_delta_x,
  input  wire logic signed [15:0]                   in_delta_y,
  input  wire logic signed [16:0]                   in_pos_x,
  input  wire logic signed [16:0]                   in_pos_y,
  input  wire logic [31:0]                          in_button_mask,
  input  wire logic                                 in_button_down,
  input  wire logic signed [15:0]                   in_wheel_delta,
  input  wire logic                                 in_present_value,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [31:0]                        out_cur_x,
  output logic signed [31:0]                        out_cur_y,
  output logic [31:0]                               out_cur_buttons,
  output logic signed [31:0]                        out_wheel_taken,
  output logic                                      out_is_present
);

  // Saturating signed add of a 32-bit total and a 16-bit step.
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [15:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s[32] != s[31]) begin
      sat_add = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

  // Clamp to 0..size-1 unless the size is unknown.
  function automatic logic signed [31:0] clamp_axis(input logic signed [31:0] v,
                                                    input logic [15:0] size);
    logic signed [31:0] top;
    top = $signed({16'd0, size - 16'd1});
    if (size == 16'd0) begin
      clamp_axis = v;
    end else if (v < 0) begin
      clamp_axis = '0;
    end else if (v > top) begin
      clamp_axis = top;
    end else begin
      clamp_axis = v;
    end
  endfunction

  logic [15:0]        screen_w_r;
  logic [15:0]        screen_h_r;
  logic signed [31:0] pointer_x_r, pointer_x_nxt;
  logic signed [31:0] pointer_y_r, pointer_y_nxt;
  logic [31:0]        buttons_r, buttons_nxt;
  logic signed [31:0] wheel_r, wheel_nxt;
  logic               present_r, present_nxt;
  logic               seeded_r, seeded_nxt;
  logic signed [31:0] wheel_out;
  logic signed [31:0] base_x, base_y;
  logic               out_valid_r;
  logic signed [31:0] out_cur_x_r;
  logic signed [31:0] out_cur_y_r;
  logic [31:0]        out_cur_buttons_r;
  logic signed [31:0] out_wheel_taken_r;
  logic               out_is_present_r;
  logic               accept;
  ppt_pkg::action_t   act;

  assign act      = ppt_pkg::action_t'(in_action);
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_cur_x       = out_cur_x_r;
  assign out_cur_y       = out_cur_y_r;
  assign out_cur_buttons = out_cur_buttons_r;
  assign out_wheel_taken = out_wheel_taken_r;
  assign out_is_present  = out_is_present_r;

  // Seed base: stored position, or screen centre when not yet seeded.
  always_comb begin
    if (seeded_r) begin
      base_x = pointer_x_r;
      base_y = pointer_y_r;
    end else begin
      base_x = $signed({17'd0, screen_w_r[15:1]});
      base_y = $signed({17'd0, screen_h_r[15:1]});
    end
  end

  // Next state for one event.
  always_comb begin
    pointer_x_nxt = pointer_x_r;
    pointer_y_nxt = pointer_y_r;
    buttons_nxt   = buttons_r;
    wheel_nxt     = wheel_r;
    present_nxt   = present_r;
    seeded_nxt    = seeded_r;
    unique case (act)
      ppt_pkg::ACT_MOVE_REL: begin
        pointer_x_nxt = clamp_axis(sat_add(base_x, in_delta_x), screen_w_r);
        pointer_y_nxt = clamp_axis(sat_add(base_y, in_delta_y), screen_h_r);
        seeded_nxt    = 1'b1;
        present_nxt   = 1'b1;
      end
      ppt_pkg::ACT_MOVE_ABS: begin
        pointer_x_nxt = clamp_axis(32'(in_pos_x), screen_w_r);
        pointer_y_nxt = clamp_axis(32'(in_pos_y), screen_h_r);
        seeded_nxt    = 1'b1;
        present_nxt   = 1'b1;
      end
      ppt_pkg::ACT_BUTTON: begin
        buttons_nxt = in_button_down ? (buttons_r | in_button_mask)
                                     : (buttons_r & ~in_button_mask);
        present_nxt = 1'b1;
      end
      ppt_pkg::ACT_WHEEL: begin
        wheel_nxt   = sat_add(wheel_r, in_wheel_delta);
        present_nxt = 1'b1;
      end
      ppt_pkg::ACT_TAKE_WHEEL: begin
        wheel_nxt = '0;
      end
      ppt_pkg::ACT_QUERY: begin
        pointer_x_nxt = base_x;
        pointer_y_nxt = base_y;
        seeded_nxt    = 1'b1;
      end
      ppt_pkg::ACT_SET_PRESENT: begin
        present_nxt = in_present_value;
      end
      ppt_pkg::ACT_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // Take reports the total before clearing it.
  assign wheel_out = (act == ppt_pkg::ACT_TAKE_WHEEL) ? wheel_r : wheel_nxt;

  // Hold screen size.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r <= '0;
      screen_h_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppt_pkg::CFG_SCREEN_WIDTH:  screen_w_r <= cfg_data;
        ppt_pkg::CFG_SCREEN_HEIGHT: screen_h_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Advance tracker state on each accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pointer_x_r <= '0;
      pointer_y_r <= '0;
      buttons_r   <= '0;
      wheel_r     <= '0;
      present_r   <= 1'b0;
      seeded_r    <= 1'b0;
    end else if (accept) begin
      pointer_x_r <= pointer_x_nxt;
      pointer_y_r <= pointer_y_nxt;
      buttons_r   <= buttons_nxt;
      wheel_r     <= wheel_nxt;
      present_r   <= present_nxt;
      seeded_r    <= seeded_nxt;
    end
  end

  // Result valid: set on accept, drop when taken with nothing new.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  // Load the snapshot.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_cur_x_r       <= pointer_x_nxt;
      out_cur_y_r       <= pointer_y_nxt;
      out_cur_buttons_r <= buttons_nxt;
      out_wheel_taken_r <= wheel_out;
      out_is_present_r  <= present_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ppt_checker.sv =====
// Port-level checker for the pointer position tracker, bound to the top level.
`default_nettype none
`include "pointer_position_tracker_top_defines.svh"

module ppt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [2:0]  in_action,
  input wire logic [31:0] in_button_mask,
  input wire logic        in_button_down,
  input wire logic        in_present_value,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_cur_x,
  input wire logic [31:0] out_cur_buttons,
  input wire logic        out_is_present
);

  logic acc;
  assign acc = rst_n && in_valid && in_ready;

  // A stalled result holds.
  `PPT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_cur_x), "result dropped or changed while stalled")

  // Every accepted beat gives a result next cycle.
  `PPT_ASSERT_NEXT(a_accept_result, acc, out_valid, "accepted beat produced no result")

  // A pressed button shows in the snapshot.
  `PPT_ASSERT_NEXT(a_button_set, acc && in_button_down && (in_action == ppt_pkg::ACT_BUTTON), (out_cur_buttons & $past(in_button_mask)) == $past(in_button_mask), "pressed buttons missing")

  // Set-present reports the written flag.
  `PPT_ASSERT_NEXT(a_set_present, acc && (in_action == ppt_pkg::ACT_SET_PRESENT), out_is_present == $past(in_present_value), "present flag mismatch")

  // Ready never drops while the result register is empty.
  `PPT_ASSERT_NOW(a_ready_empty, !out_valid, in_ready, "not ready with empty result")

endmodule

bind pointer_position_tracker_top ppt_checker u_ppt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_action        (in_action),
  .in_button_mask   (in_button_mask),
  .in_button_down   (in_button_down),
  .in_present_value (in_present_value),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_cur_x        (out_cur_x),
  .out_cur_buttons  (out_cur_buttons),
  .out_is_present   (out_is_present)
);

`default_nettype wire
